// ===== src/abs_pkg.sv =====
// Shared constants and types for the alternating-bit sender.
// No dependencies; every other file imports this package, except abs_ram.
`default_nettype none
package abs_pkg;
    localparam int PAYLOAD_BYTES = 20;
    localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int SEQ_W         = 20;
    localparam int SUM_W         = 25;
    localparam int BYTE_W        = 8;
    localparam int BITCNT_W      = $clog2(BYTE_W);
    localparam int WGT_W         = 22;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);

    localparam logic [SUM_W-1:0] CHECK_MOD  = 25'd19260817;
    localparam logic [WGT_W-1:0] CHECK_BASE = 22'd114514;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(PAYLOAD_BYTES - 1);

    localparam logic CMD_MSG = 1'b0;
    localparam logic CMD_ACK = 1'b1;

    typedef struct packed {
        logic             seq_bit;
        logic [SUM_W-1:0] check;
    } t_job;
endpackage
`default_nettype wire

// ===== src/abs_if.sv =====
// Handshake channels of the alternating-bit sender: input word and output word.
// Depends on abs_pkg.
`default_nettype none
interface abs_in_if;
    import abs_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [SEQ_W-1:0]  seq_number;
    logic [SEQ_W-1:0]  ack_number;
    logic [SUM_W-1:0]  check_value;
    logic [BYTE_W-1:0] payload_byte;

    modport source (output valid, command, seq_number, ack_number, check_value,
                    payload_byte, input ready);
    modport sink   (input valid, command, seq_number, ack_number, check_value,
                    payload_byte, output ready);
endinterface

interface abs_out_if;
    import abs_pkg::*;
    logic              valid;
    logic              ready;
    logic              out_seq;
    logic              out_ack;
    logic [SUM_W-1:0]  out_check;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, out_seq, out_ack, out_check, out_byte, out_last,
                    input ready);
    modport sink   (input valid, out_seq, out_ack, out_check, out_byte, out_last,
                    output ready);
endinterface
`default_nettype wire

// ===== src/abs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module abs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/abs_front.sv =====
// Front end: takes input words, keeps phase, byte index and running checksum,
// stores message bytes and issues send jobs. Depends on abs_pkg, abs_if.
`default_nettype none
module abs_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    abs_in_if.sink                           i_in,
    input  wire logic                        i_pkt_busy,
    output logic                             o_job_valid,
    output abs_pkg::t_job                    o_job,
    input  wire logic                        i_job_ready,
    output logic                             o_ram_we,
    output logic [abs_pkg::IDX_W-1:0]        o_ram_waddr,
    output logic [abs_pkg::BYTE_W-1:0]       o_ram_wdata
);
    import abs_pkg::*;

    typedef enum logic [2:0] {
        F_READY = 3'b001,
        F_MUL   = 3'b010,
        F_ACC   = 3'b100
    } t_fstate;

    t_fstate             r_state;
    logic                r_waiting;
    logic                r_seq_bit;
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_check;
    logic [WGT_W-1:0]    r_wgt;
    logic [BYTE_W-1:0]   r_byte;
    logic [SUM_W-1:0]    r_acc;
    logic [BITCNT_W-1:0] r_bitcnt;
    logic                r_last;
    logic                r_is_ack;
    logic [SUM_W-1:0]    r_chk;
    logic                r_ack_ok;

    logic              msg_item;
    logic              ack_item;
    logic              accept;
    logic [SEQ_W-1:0]  seq_sel;
    logic [SEQ_W-1:0]  ack_sel;
    logic [WGT_W-1:0]  wgt;
    logic [SUM_W:0]    dbl;
    logic [SUM_W:0]    dbl_red;
    logic [SUM_W:0]    addw;
    logic [SUM_W:0]    addw_red;
    logic [SUM_W:0]    total;
    logic [SUM_W-1:0]  n_sum;
    logic              clean_hit;

    assign msg_item = (i_in.command == CMD_MSG) && !r_waiting;
    assign ack_item = (i_in.command == CMD_ACK) && r_waiting;

    // message bytes wait until the previous packet has drained from the buffer
    assign i_in.ready = (r_state == F_READY) && !(msg_item && i_pkt_busy);
    assign accept     = i_in.valid && i_in.ready;

    assign seq_sel = r_waiting ? i_in.seq_number : {{(SEQ_W-1){1'b0}}, r_seq_bit};
    assign ack_sel = r_waiting ? i_in.ack_number : '0;
    assign wgt     = WGT_W'(seq_sel) + WGT_W'(ack_sel) + WGT_W'(r_idx) + CHECK_BASE;

    // one multiplier bit per cycle, MSB first, kept below the modulus
    always_comb begin
        dbl      = {r_acc, 1'b0};
        dbl_red  = (dbl >= {1'b0, CHECK_MOD}) ? dbl - {1'b0, CHECK_MOD} : dbl;
        addw     = dbl_red + (r_byte[BYTE_W-1] ? (SUM_W+1)'(r_wgt) : '0);
        addw_red = (addw >= {1'b0, CHECK_MOD}) ? addw - {1'b0, CHECK_MOD} : addw;
        total    = {1'b0, r_sum} + {1'b0, r_acc};
        n_sum    = (total >= {1'b0, CHECK_MOD}) ? SUM_W'(total - {1'b0, CHECK_MOD})
                                                : total[SUM_W-1:0];
    end

    assign clean_hit   = (n_sum == r_chk) && r_ack_ok;
    assign o_job_valid = (r_state == F_ACC) && r_last && !(r_is_ack && clean_hit);
    assign o_job.seq_bit = r_seq_bit;
    assign o_job.check   = r_is_ack ? r_check : n_sum;

    assign o_ram_we    = accept && msg_item;
    assign o_ram_waddr = r_idx;
    assign o_ram_wdata = i_in.payload_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_READY;
            r_waiting <= 1'b0;
            r_seq_bit <= 1'b0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_check   <= '0;
        end else begin
            case (r_state)
                F_READY: begin
                    if (accept && (msg_item || ack_item)) begin
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    if (r_bitcnt == BITCNT_W'(BYTE_W - 1)) begin
                        r_state <= F_ACC;
                    end
                end
                F_ACC: begin
                    if (!r_last) begin
                        r_sum   <= n_sum;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= F_READY;
                    end else if (r_is_ack && clean_hit) begin
                        r_sum     <= '0;
                        r_idx     <= '0;
                        r_seq_bit <= !r_seq_bit;
                        r_waiting <= 1'b0;
                        r_state   <= F_READY;
                    end else if (i_job_ready) begin
                        r_sum   <= '0;
                        r_idx   <= '0;
                        r_state <= F_READY;
                        if (!r_is_ack) begin
                            r_check   <= n_sum;
                            r_waiting <= 1'b1;
                        end
                    end
                end
                default: r_state <= F_READY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_READY) begin
            r_wgt    <= wgt;
            r_byte   <= i_in.payload_byte;
            r_acc    <= '0;
            r_bitcnt <= '0;
            r_last   <= (r_idx == LAST_IDX);
            r_is_ack <= r_waiting;
            r_chk    <= i_in.check_value;
            r_ack_ok <= (i_in.ack_number == {{(SEQ_W-1){1'b0}}, r_seq_bit});
        end else if (r_state == F_MUL) begin
            r_acc    <= addw_red[SUM_W-1:0];
            r_byte   <= {r_byte[BYTE_W-2:0], 1'b0};
            r_bitcnt <= r_bitcnt + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== src/abs_queue.sv =====
// Short job queue between front end and back end.
// Depends on abs_pkg.
`default_nettype none
module abs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    input  wire abs_pkg::t_job i_push_job,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output abs_pkg::t_job      o_pop_job,
    input  wire logic          i_pop_ready
);
    import abs_pkg::*;

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end
endmodule
`default_nettype wire

// ===== src/abs_back.sv =====
// Back end: plays one packet out of the resend buffer per job, one word per byte.
// Depends on abs_pkg, abs_if.
`default_nettype none
module abs_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_job_valid,
    input  wire abs_pkg::t_job           i_job,
    output logic                         o_job_ready,
    output logic                         o_ram_re,
    output logic [abs_pkg::IDX_W-1:0]    o_ram_raddr,
    input  wire logic [abs_pkg::BYTE_W-1:0] i_ram_rdata,
    abs_out_if.source                    o_out,
    output logic                         o_busy
);
    import abs_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_SEND  = 3'b100
    } t_bstate;

    t_bstate          r_state;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;

    assign o_job_ready = (r_state == B_IDLE);
    assign o_busy      = (r_state != B_IDLE);
    assign o_ram_re    = (r_state == B_FETCH);
    assign o_ram_raddr = r_idx;

    assign o_out.valid     = (r_state == B_SEND);
    assign o_out.out_seq   = r_job.seq_bit;
    assign o_out.out_ack   = 1'b0;
    assign o_out.out_check = r_job.check;
    assign o_out.out_byte  = i_ram_rdata;
    assign o_out.out_last  = (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_idx   <= '0;
                        r_state <= B_FETCH;
                    end
                end
                B_FETCH: r_state <= B_SEND;
                B_SEND: begin
                    if (o_out.ready) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= B_FETCH;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid) begin
            r_job <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== src/alternating_bit_sender.sv =====
// Alternating-bit sender: front end, job queue, back end and resend buffer RAM.
// Depends on abs_pkg, abs_if, abs_ram, abs_front, abs_queue, abs_back.
//
// Stop-and-wait sender. Each input word is a message byte (command 0) or an
// ack packet byte (command 1); a packet is PAYLOAD_BYTES words. A message or ack
// byte that is used is taken, multiplied bit-serially (weight times byte, mod
// 19260817) and then accumulated before the front end takes the next word; the
// last byte of a packet stays longer while the job queue is full.
// Words that do not apply to the current phase are taken and dropped. A complete
// message, or a failed ack, queues a packet that leaves on the output channel
// word by word: each byte is read from the registered resend buffer and then
// sent once the output is ready. Ack bytes are taken while a packet is going out;
// message bytes are held off until the outgoing packet has fully left.
`default_nettype none
module alternating_bit_sender (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abs_in_if.sink    i_in,
    abs_out_if.source o_out
);
    import abs_pkg::*;

    t_job              front_job;
    logic              front_job_valid;
    logic              front_job_ready;
    t_job              q_job;
    logic              q_valid;
    logic              back_ready;
    logic              back_busy;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              pkt_busy;

    assign pkt_busy = q_valid || back_busy;

    abs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_pkt_busy  (pkt_busy),
        .o_job_valid (front_job_valid),
        .o_job       (front_job),
        .i_job_ready (front_job_ready),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    abs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_job_valid),
        .i_push_job   (front_job),
        .o_push_ready (front_job_ready),
        .o_pop_valid  (q_valid),
        .o_pop_job    (q_job),
        .i_pop_ready  (back_ready)
    );

    abs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    abs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_ready (back_ready),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out       (o_out),
        .o_busy      (back_busy)
    );
endmodule
`default_nettype wire

// ===== sim/tb_alternating_bit_sender.sv =====
// Testbench for the alternating-bit sender: random and directed byte streams,
// in-order checking of every transmitted word against a behavioral predictor.
// Depends on abs_pkg, abs_if and the alternating_bit_sender RTL.
module tb_alternating_bit_sender;
    timeunit 1ns;
    timeprecision 1ps;
    import abs_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
        logic [SUM_W-1:0]  chk;
        logic [BYTE_W-1:0] data;
    } t_word;

    typedef struct packed {
        t_word w;
        logic  drain;
    } t_pending;

    typedef struct packed {
        logic              seq_bit;
        logic              ack;
        logic [SUM_W-1:0]  check;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_packet_word;

    typedef struct packed {
        logic                                  seq_bit;
        logic                                  waiting;
        logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0]  buffer;
        logic [SUM_W-1:0]                      held_check;
        logic [SUM_W-1:0]                      sum;
        logic [IDX_W-1:0]                      idx;
    } t_sender;

    typedef enum {EV_DROP, EV_TAKE, EV_SEND, EV_DONE} t_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    abs_in_if  in_if();
    abs_out_if out_if();

    alternating_bit_sender DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic  drv_valid = 1'b0;
    t_word drv_word  = '0;
    logic  rx_ready  = 1'b0;

    assign in_if.valid        = drv_valid;
    assign in_if.command      = drv_word.cmd;
    assign in_if.seq_number   = drv_word.seq;
    assign in_if.ack_number   = drv_word.ack;
    assign in_if.check_value  = drv_word.chk;
    assign in_if.payload_byte = drv_word.data;
    assign out_if.ready       = rx_ready;

    t_pending     pending[$];
    t_packet_word sent_words[$];
    t_sender      model = '0;
    t_sender      plan  = '0;
    logic         hold_next = 1'b0;
    int           planned = 0;
    int           errors = 0;
    int           words_in = 0;
    int           words_dropped = 0;
    int           words_out = 0;
    int           packets = 0;
    int           resends = 0;
    int           acks_done = 0;

    function automatic logic [SUM_W-1:0] weigh(logic [SUM_W-1:0] sum, logic [SEQ_W-1:0] sq,
                                               logic [SEQ_W-1:0] ak, logic [IDX_W-1:0] idx,
                                               logic [BYTE_W-1:0] b);
        longint unsigned m;
        longint unsigned wgt;
        m   = 64'(CHECK_MOD);
        wgt = (64'(sq) + 64'(ak) + 64'(idx) + 64'(CHECK_BASE)) % m;
        return SUM_W'((64'(sum) + wgt * 64'(b)) % m);
    endfunction

    function automatic t_step sender_step(inout t_sender s, input t_word w);
        logic cur;
        logic at_end;
        logic clean;
        cur = s.seq_bit;
        if (s.idx >= IDX_W'(PAYLOAD_BYTES)) begin
            s.idx = '0;
            s.sum = '0;
        end
        at_end = (s.idx == LAST_IDX);
        if (!s.waiting) begin
            if (w.cmd != CMD_MSG) return EV_DROP;
            s.buffer[s.idx] = w.data;
            s.sum = weigh(s.sum, {19'd0, cur}, '0, s.idx, w.data);
            if (!at_end) begin
                s.idx = s.idx + 1'b1;
                return EV_TAKE;
            end
            s.held_check = s.sum;
            s.sum = '0;
            s.idx = '0;
            s.waiting = 1'b1;
            return EV_SEND;
        end
        if (w.cmd != CMD_ACK) return EV_DROP;
        s.sum = weigh(s.sum, w.seq, w.ack, s.idx, w.data);
        if (!at_end) begin
            s.idx = s.idx + 1'b1;
            return EV_TAKE;
        end
        clean = (s.sum == w.chk);
        s.sum = '0;
        s.idx = '0;
        if (clean && w.ack == {19'd0, cur}) begin
            s.seq_bit = ~cur;
            s.waiting = 1'b0;
            return EV_DONE;
        end
        return EV_SEND;
    endfunction

    function automatic logic [SEQ_W-1:0] pick20();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return SEQ_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick8();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic t_word noise_word(logic cmd);
        t_word w;
        w.cmd  = cmd;
        w.seq  = pick20();
        w.ack  = pick20();
        w.chk  = SUM_W'($urandom);
        w.data = pick8();
        return w;
    endfunction

    task automatic queue_word(input t_word w);
        void'(sender_step(plan, w));
        planned++;
        pending.push_back(t_pending'({w, hold_next}));
        hold_next = 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // driver: bursts with random gaps, optional hold until all output words are back
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid  <= 1'b0;
            burst_left <= $urandom_range(1, 30);
            gap_left   <= 0;
        end else if (!drv_valid || in_if.ready) begin
            if (gap_left != 0) begin
                gap_left  <= gap_left - 1;
                drv_valid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain && (drv_valid || sent_words.size() != 0))) begin
                drv_word  <= pending[0].w;
                void'(pending.pop_front());
                drv_valid <= 1'b1;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 4) == 0) begin
                        burst_left <= $urandom_range(100, 300);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= $urandom_range(0, 8);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: always ready, rotating mask, or coin flip
    int         rx_mode = 0;
    int         rx_left = 0;
    logic [15:0] rx_pat = 16'h1;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 200);
            rx_pat  <= 16'($urandom) | 16'h1;
        end else begin
            rx_left <= rx_left - 1;
            rx_pat  <= {rx_pat[14:0], rx_pat[15]};
        end
        case (rx_mode)
            0: rx_ready <= 1'b1;
            1: rx_ready <= rx_pat[0];
            default: rx_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // monitor: check output words, then predict from accepted input words
    always @(posedge i_clk) begin
        t_packet_word got;
        t_packet_word want;
        t_word        w;
        t_step        ev;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = {out_if.out_seq, out_if.out_ack, out_if.out_check, out_if.out_byte,
                       out_if.out_last};
                words_out++;
                if (sent_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output word, expected none, got %0h",
                             $realtime, got);
                end else begin
                    want = sent_words.pop_front();
                    check_field("out_seq", want.seq_bit, got.seq_bit);
                    check_field("out_ack", want.ack, got.ack);
                    check_field("out_check", want.check, got.check);
                    check_field("out_byte", want.data, got.data);
                    check_field("out_last", want.last, got.last);
                end
            end
            if (in_if.valid && in_if.ready) begin
                w = {in_if.command, in_if.seq_number, in_if.ack_number, in_if.check_value,
                     in_if.payload_byte};
                words_in++;
                ev = sender_step(model, w);
                if (ev == EV_DROP) words_dropped++;
                if (ev == EV_DONE) acks_done++;
                if (ev == EV_SEND) begin
                    packets++;
                    if (w.cmd == CMD_ACK) resends++;
                    for (int k = 0; k < PAYLOAD_BYTES; k++)
                        sent_words.push_back({model.seq_bit, 1'b0, model.held_check,
                                              model.buffer[k], k == PAYLOAD_BYTES - 1});
                end
            end
        end
    end

    initial begin
        t_word             w;
        int                kind;
        logic              vary;
        logic [SEQ_W-1:0]  seq_fix;
        logic [SEQ_W-1:0]  ack_fix;
        logic [SEQ_W-1:0]  cur;
        logic [SUM_W-1:0]  mask;

        // directed: acks while idle, one message of extreme bytes, messages while waiting
        w = '0;
        w.cmd = CMD_ACK;
        queue_word(w);
        queue_word(t_word'({CMD_ACK, {(2 * SEQ_W + SUM_W + BYTE_W){1'b1}}}));
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            w = noise_word(CMD_MSG);
            w.data = (k % 3 == 0) ? 8'h00 : (k % 3 == 1) ? 8'hFF : BYTE_W'(k * 37);
            queue_word(w);
        end
        w = '0;
        w.cmd = CMD_MSG;
        queue_word(w);
        queue_word(t_word'({CMD_MSG, {(2 * SEQ_W + SUM_W + BYTE_W){1'b1}}}));

        hold_next = 1'b1;
        while (planned < 170) begin
            if ($urandom_range(0, 5) == 0) hold_next = 1'b1;
            if (!plan.waiting) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) queue_word(noise_word(CMD_ACK));
                end else begin
                    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                        if ($urandom_range(0, 7) == 0) queue_word(noise_word(CMD_ACK));
                        queue_word(noise_word(CMD_MSG));
                    end
                end
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) queue_word(noise_word(CMD_MSG));
            end else begin
                // 0-4 clean, 5-6 wrong ack number, 7-9 bad checksum
                kind    = $urandom_range(0, 9);
                vary    = ($urandom_range(0, 2) == 0);
                cur     = {19'd0, plan.seq_bit};
                seq_fix = pick20();
                ack_fix = cur;
                if (kind == 5 || kind == 6) begin
                    case ($urandom_range(0, 2))
                        0: ack_fix = {19'd0, ~plan.seq_bit};
                        1: ack_fix = cur | (20'd1 << $urandom_range(1, 19));
                        default: begin
                            ack_fix = pick20();
                            if (ack_fix == cur) ack_fix = ack_fix ^ 20'h80000;
                        end
                    endcase
                end
                for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                    if ($urandom_range(0, 9) == 0) queue_word(noise_word(CMD_MSG));
                    w = noise_word(CMD_ACK);
                    if (!vary) begin
                        w.seq = seq_fix;
                        w.ack = ack_fix;
                    end
                    if (k == PAYLOAD_BYTES - 1) begin
                        w.ack = ack_fix;
                        w.chk = weigh(plan.sum, w.seq, w.ack, plan.idx, w.data);
                        if (kind >= 7) begin
                            if ($urandom_range(0, 1) == 0) mask = SUM_W'(1) << $urandom_range(0, 24);
                            else mask = SUM_W'($urandom);
                            if (mask == '0) mask = SUM_W'(1);
                            w.chk = w.chk ^ mask;
                        end
                    end
                    queue_word(w);
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || drv_valid) @(posedge i_clk);
        while (sent_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("input words %0d (%0d dropped), output words %0d checked", words_in,
                 words_dropped, words_out);
        $display("packets sent %0d, of them resends %0d, acks accepted %0d", packets,
                 resends, acks_done);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/abs_pkg.sv
src/abs_if.sv
src/abs_ram.sv
src/abs_front.sv
src/abs_queue.sv
src/abs_back.sv
src/alternating_bit_sender.sv
sim/tb_alternating_bit_sender.sv
